### src/oast_pkg.sv
package oast_pkg;

    // table geometry
    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // field widths
    localparam int ACT_W   = 3;
    localparam int TIME_W  = 32;
    localparam int REG_W   = 24;
    localparam int TAG_W   = 8;
    localparam int ID_W    = 8;
    localparam int SLOT_W  = 7;
    localparam int CIDX_W  = 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TAKE   = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MAX_DELAY   = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_RECLAIM_AGE = 1'b1;

    // register reset values
    localparam logic [REG_W-1:0] MAX_DELAY_RST   = 24'd86400;
    localparam logic [REG_W-1:0] RECLAIM_AGE_RST = 24'd600;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SET,
        S_LOOK,
        S_SCAN,
        S_EMIT,
        S_RESP
    } t_state;

endpackage

### src/owned_alarm_slot_table_unit.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_action i_now_seconds i_delay_seconds
//          |              |              | i_alarm_id i_owner_tag
// output   | o_out_valid  | i_out_stall  | o_ok o_slot_id o_seconds_left
//          |              |              | o_nearest_deadline o_last
// config   | i_cfg_we     | (none)       | i_cfg_index i_cfg_data
//
// set: clamp on acceptance, a deadline step, 1 to NUM_SLOTS slot visits, then hand off
// scan: NUM_SLOTS slot visits, then one result beat per fired slot (or one empty beat)
// cancel and query: one slot lookup then hand off; take event and unknown codes: hand off only
// the single slot read/write port and the one deadline compare unit set these step sequences
// synchronous active-low reset clears the slot table and event flag and loads the config registers' reset values
// o_in_stall is high after acceptance until the last result beat is loaded into the output
// register; a stalled output beat holds, and the sequencer waits behind it
module owned_alarm_slot_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config
    input  logic                              i_cfg_we,
    input  logic [oast_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [oast_pkg::REG_W-1:0]        i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [oast_pkg::ACT_W-1:0]        i_action,
    input  logic [oast_pkg::TIME_W-1:0]       i_now_seconds,
    input  logic signed [oast_pkg::TIME_W-1:0] i_delay_seconds,
    input  logic [oast_pkg::ID_W-1:0]         i_alarm_id,
    input  logic [oast_pkg::TAG_W-1:0]        i_owner_tag,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_ok,
    output logic [oast_pkg::SLOT_W-1:0]       o_slot_id,
    output logic [oast_pkg::REG_W-1:0]        o_seconds_left,
    output logic [oast_pkg::TIME_W-1:0]       o_nearest_deadline,
    output logic                              o_last
);
    import oast_pkg::*;

    // configuration
    logic [REG_W-1:0]  r_max_delay;
    logic [REG_W-1:0]  r_reclaim;

    // slot table, one read/write port at r_idx
    logic              r_used  [NUM_SLOTS];
    logic              r_fired [NUM_SLOTS];
    logic [TIME_W-1:0] r_dl    [NUM_SLOTS];
    logic [TAG_W-1:0]  r_owner [NUM_SLOTS];
    logic              r_event, n_event;

    // sequencer
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [REG_W-1:0]  r_delay, n_delay;
    logic              r_found, n_found;
    logic [TIME_W-1:0] r_acc, n_acc;     // set: deadline, scan: nearest pending deadline
    logic              r_have, n_have;
    logic [NUM_SLOTS-1:0] r_mask, n_mask; // slots fired by this scan

    // staged single result
    logic              r_res_ok, n_res_ok;
    logic [SLOT_W-1:0] r_res_id, n_res_id;
    logic [REG_W-1:0]  r_res_left, n_res_left;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [SLOT_W-1:0] r_out_id, n_out_id;
    logic [REG_W-1:0]  r_out_left, n_out_left;
    logic [TIME_W-1:0] r_out_near, n_out_near;
    logic              r_out_last, n_out_last;

    // slot write port
    logic              w_we;
    logic              w_wused;
    logic              w_wfired;
    logic [TIME_W-1:0] w_wdl;
    logic [TAG_W-1:0]  w_wown;

    // slot read and shared compare unit
    logic              w_used, w_fired;
    logic [TIME_W-1:0] w_dl;
    logic [TAG_W-1:0]  w_own;
    logic              w_accept, w_out_free, w_idx_end;
    logic [TIME_W-1:0] w_age, w_rem;
    logic              w_reclaim, w_due;
    logic [REG_W-1:0]  w_hi;
    logic [IDX_W-1:0]  w_id_m1;
    logic [TIME_W:0]   w_sum;
    logic [IDX_W-1:0]  w_low;
    logic [NUM_SLOTS-1:0] w_rest;
    logic              w_hit;

    assign w_used  = r_used[r_idx];
    assign w_fired = r_fired[r_idx];
    assign w_dl    = r_dl[r_idx];
    assign w_own   = r_owner[r_idx];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_idx_end  = (r_idx == IDX_W'(NUM_SLOTS - 1));

    assign w_age     = r_now - w_dl;
    assign w_rem     = w_dl - r_now;
    assign w_reclaim = w_used && w_fired && (r_now > w_dl) && (w_age > {8'd0, r_reclaim});
    assign w_due     = (w_dl <= r_now);
    assign w_hit     = r_found && w_used && (w_own == r_tag);

    assign w_hi    = (r_max_delay == '0) ? REG_W'(1) : r_max_delay;
    assign w_id_m1 = IDX_W'(i_alarm_id - ID_W'(1));
    assign w_sum   = {1'b0, r_now} + {{(TIME_W - REG_W + 1){1'b0}}, r_delay};

    // lowest fired slot still to report
    always_comb begin
        w_low = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low = IDX_W'(i);
            end
        end
    end
    assign w_rest = r_mask & ~(NUM_SLOTS'(1) << w_low);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_act      = r_act;
        n_now      = r_now;
        n_tag      = r_tag;
        n_delay    = r_delay;
        n_found    = r_found;
        n_acc      = r_acc;
        n_have     = r_have;
        n_mask     = r_mask;
        n_event    = r_event;
        n_res_ok   = r_res_ok;
        n_res_id   = r_res_id;
        n_res_left = r_res_left;

        n_out_valid = r_out_valid && i_out_stall;
        n_out_ok    = r_out_ok;
        n_out_id    = r_out_id;
        n_out_left  = r_out_left;
        n_out_near  = r_out_near;
        n_out_last  = r_out_last;

        w_we     = 1'b0;
        w_wused  = 1'b0;
        w_wfired = 1'b0;
        w_wdl    = '0;
        w_wown   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act      = i_action;
                    n_now      = i_now_seconds;
                    n_tag      = i_owner_tag;
                    n_res_ok   = 1'b0;
                    n_res_id   = '0;
                    n_res_left = '0;
                    n_acc      = '0;
                    n_have     = 1'b0;
                    n_mask     = '0;
                    n_idx      = '0;
                    unique case (i_action)
                        ACT_SET: begin
                            // clamp to 1 .. max_delay (1 when max_delay is zero), negative and zero go to 1
                            if (i_delay_seconds[TIME_W-1] || i_delay_seconds == '0) begin
                                n_delay = REG_W'(1);
                            end else if (i_delay_seconds > $signed({8'd0, w_hi})) begin
                                n_delay = w_hi;
                            end else begin
                                n_delay = i_delay_seconds[REG_W-1:0];
                            end
                            n_state = S_PREP;
                        end
                        ACT_CANCEL, ACT_QUERY: begin
                            n_found = (i_alarm_id != '0) && (i_alarm_id <= ID_W'(NUM_SLOTS));
                            n_idx   = w_id_m1;
                            n_state = S_LOOK;
                        end
                        ACT_SCAN: begin
                            n_state = S_SCAN;
                        end
                        ACT_TAKE: begin
                            n_res_ok = r_event;
                            n_event  = 1'b0;
                            n_state  = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PREP: begin
                // saturating deadline
                n_acc   = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
                n_state = S_SET;
            end
            S_SET: begin
                if (!w_used || w_reclaim) begin
                    w_we     = 1'b1;
                    w_wused  = 1'b1;
                    w_wfired = 1'b0;
                    w_wdl    = r_acc;
                    w_wown   = r_tag;
                    n_res_ok = 1'b1;
                    n_res_id = SLOT_W'(r_idx) + SLOT_W'(1);
                    n_state  = S_RESP;
                end else if (w_idx_end) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_LOOK: begin
                n_res_ok = w_hit;
                if (r_act == ACT_CANCEL) begin
                    if (w_hit) begin
                        w_we = 1'b1;
                    end
                end else if (w_hit && !w_fired && !w_due) begin
                    n_res_left = (|w_rem[TIME_W-1:REG_W]) ? {REG_W{1'b1}} : w_rem[REG_W-1:0];
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (w_used && !w_fired) begin
                    if (w_due) begin
                        w_we          = 1'b1;
                        w_wused       = 1'b1;
                        w_wfired      = 1'b1;
                        w_wdl         = w_dl;
                        w_wown        = w_own;
                        n_mask[r_idx] = 1'b1;
                    end else if (!r_have || w_dl < r_acc) begin
                        n_acc  = w_dl;
                        n_have = 1'b1;
                    end
                end
                if (w_idx_end) begin
                    if (n_mask != '0) begin
                        n_event = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = 1'b1;
                    n_out_id    = SLOT_W'(w_low) + SLOT_W'(1);
                    n_out_left  = '0;
                    n_out_near  = r_acc;
                    n_out_last  = (w_rest == '0);
                    n_mask      = w_rest;
                    if (w_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_id    = r_res_id;
                    n_out_left  = r_res_left;
                    n_out_near  = (r_act == ACT_SCAN) ? r_acc : '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_event     <= 1'b0;
            r_max_delay <= MAX_DELAY_RST;
            r_reclaim   <= RECLAIM_AGE_RST;
            r_idx       <= '0;
            r_mask      <= '0;
            r_have      <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_used[i]  <= 1'b0;
                r_fired[i] <= 1'b0;
                r_dl[i]    <= '0;
                r_owner[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_event     <= n_event;
            r_idx       <= n_idx;
            r_mask      <= n_mask;
            r_have      <= n_have;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_DELAY:   r_max_delay <= i_cfg_data;
                    CFG_RECLAIM_AGE: r_reclaim   <= i_cfg_data;
                    default:         r_reclaim   <= r_reclaim;
                endcase
            end
            if (w_we) begin
                r_used[r_idx]  <= w_wused;
                r_fired[r_idx] <= w_wfired;
                r_dl[r_idx]    <= w_wdl;
                r_owner[r_idx] <= w_wown;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_now      <= n_now;
        r_tag      <= n_tag;
        r_delay    <= n_delay;
        r_found    <= n_found;
        r_acc      <= n_acc;
        r_res_ok   <= n_res_ok;
        r_res_id   <= n_res_id;
        r_res_left <= n_res_left;
        r_out_ok   <= n_out_ok;
        r_out_id   <= n_out_id;
        r_out_left <= n_out_left;
        r_out_near <= n_out_near;
        r_out_last <= n_out_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_ok               = r_out_ok;
    assign o_slot_id          = r_out_id;
    assign o_seconds_left     = r_out_left;
    assign o_nearest_deadline = r_out_near;
    assign o_last             = r_out_last;

    // an accepted beat keeps the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // emission only ever walks a non-empty fired set
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_mask != '0))
        else $error("emit state with no fired slot");

    // the event flag is raised only at the end of a scan
    a_event_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_event) |-> ($past(r_state) == S_SCAN))
        else $error("event flag raised outside scan");

    // a beat naming a slot always reports success
    a_id_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_slot_id != '0)) |-> o_ok)
        else $error("slot id without ok");

endmodule

### tb/sv/tb_owned_alarm_slot_table_unit.sv
`timescale 1ns / 100ps

module tb_owned_alarm_slot_table_unit;

    import oast_pkg::*;

    // one input beat and one result beat, at the block's widths
    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [TIME_W-1:0]        now;
        logic signed [TIME_W-1:0] delay;
        logic [ID_W-1:0]          id;
        logic [TAG_W-1:0]         owner;
    } alarm_req_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [REG_W-1:0]  left;
        logic [TIME_W-1:0] nearest;
        logic              last;
    } alarm_beat_t;

    // directed row: request plus an optional hand-typed reply
    typedef struct packed {
        alarm_req_t  req;
        logic        typed;
        alarm_beat_t want;
    } alarm_step_t;

    // clock and dut inputs, all known from time zero
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]        i_cfg_index = '0;
    logic [REG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ACT_W-1:0]         i_action = '0;
    logic [TIME_W-1:0]        i_now_seconds = '0;
    logic signed [TIME_W-1:0] i_delay_seconds = '0;
    logic [ID_W-1:0]          i_alarm_id = '0;
    logic [TAG_W-1:0]         i_owner_tag = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_ok;
    logic [SLOT_W-1:0]        o_slot_id;
    logic [REG_W-1:0]         o_seconds_left;
    logic [TIME_W-1:0]        o_nearest_deadline;
    logic                     o_last;

    owned_alarm_slot_table_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_now_seconds      (i_now_seconds),
        .i_delay_seconds    (i_delay_seconds),
        .i_alarm_id         (i_alarm_id),
        .i_owner_tag        (i_owner_tag),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_ok               (o_ok),
        .o_slot_id          (o_slot_id),
        .o_seconds_left     (o_seconds_left),
        .o_nearest_deadline (o_nearest_deadline),
        .o_last             (o_last)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the slot table and registers
    logic              sl_used     [NUM_SLOTS];
    logic              sl_fired    [NUM_SLOTS];
    logic [TIME_W-1:0] sl_deadline [NUM_SLOTS];
    logic [TAG_W-1:0]  sl_owner    [NUM_SLOTS];
    logic              ev_pending;
    logic [REG_W-1:0]  md_reg;
    logic [REG_W-1:0]  ra_reg;

    // replies still owed by the block, oldest first
    alarm_beat_t table_replies [$];
    int          mismatch_cnt = 0;

    // stimulus shaping
    logic              calm = 1'b0;
    logic [TIME_W-1:0] wall = '0;
    int                squeeze_asked = 0;
    int                squeeze_seen = 0;
    int                hold_cnt = 0;
    logic [TAG_W-1:0]  tag_pool [4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};

    alarm_step_t plan [$];

    // slot index for an owned, used slot, or -1
    function automatic int owned_slot(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag);
        if (id < 1 || id > NUM_SLOTS)
            return -1;
        if (!sl_used[int'(id) - 1] || sl_owner[int'(id) - 1] != tag)
            return -1;
        return int'(id) - 1;
    endfunction

    // advance the shadow table by one request, queueing every reply it owes
    task automatic step_alarm_table(input alarm_req_t r);
        logic [TIME_W-1:0] hi, dly, dl, left32, nearest;
        logic [TIME_W:0]   sum;
        logic [SLOT_W-1:0] fired_ids [$];
        logic              have;
        int                s, got;
        alarm_beat_t       b;
        b = '0;
        b.last = 1'b1;
        case (r.action)
            ACT_SET: begin
                hi  = (md_reg == 0) ? 32'd1 : {8'd0, md_reg};
                dly = r.delay;
                // negative or zero delay becomes one second
                if (dly[31] || dly == 0)
                    dly = 32'd1;
                else if (dly > hi)
                    dly = hi;
                sum = {1'b0, r.now} + {1'b0, dly};
                dl  = sum[TIME_W] ? 32'hFFFF_FFFF : sum[TIME_W-1:0];
                got = 0;
                for (int i = 0; i < NUM_SLOTS && got == 0; i++) begin
                    // free slot, or fired one past its reclaim age
                    if (!sl_used[i] || (sl_fired[i] && r.now > sl_deadline[i] &&
                            (r.now - sl_deadline[i]) > {8'd0, ra_reg})) begin
                        sl_used[i]     = 1'b1;
                        sl_fired[i]    = 1'b0;
                        sl_deadline[i] = dl;
                        sl_owner[i]    = r.owner;
                        got = i + 1;
                    end
                end
                b.ok   = (got != 0);
                b.slot = got[SLOT_W-1:0];
                table_replies.push_back(b);
            end
            ACT_CANCEL: begin
                s = owned_slot(r.id, r.owner);
                if (s >= 0) begin
                    sl_used[s]     = 1'b0;
                    sl_fired[s]    = 1'b0;
                    sl_deadline[s] = '0;
                    sl_owner[s]    = '0;
                end
                b.ok = (s >= 0);
                table_replies.push_back(b);
            end
            ACT_QUERY: begin
                s = owned_slot(r.id, r.owner);
                if (s >= 0 && !sl_fired[s] && sl_deadline[s] > r.now) begin
                    left32 = sl_deadline[s] - r.now;
                    b.left = (left32 > 32'h00FF_FFFF) ? 24'hFF_FFFF : left32[REG_W-1:0];
                end
                b.ok = (s >= 0);
                table_replies.push_back(b);
            end
            ACT_SCAN: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (sl_used[i] && !sl_fired[i] && sl_deadline[i] <= r.now) begin
                        sl_fired[i] = 1'b1;
                        fired_ids.push_back(SLOT_W'(i + 1));
                    end
                end
                // nearest deadline among what is still pending after firing
                have    = 1'b0;
                nearest = '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (sl_used[i] && !sl_fired[i] && (!have || sl_deadline[i] < nearest)) begin
                        nearest = sl_deadline[i];
                        have    = 1'b1;
                    end
                end
                b.nearest = nearest;
                if (fired_ids.size() == 0) begin
                    table_replies.push_back(b);
                end else begin
                    ev_pending = 1'b1;
                    foreach (fired_ids[k]) begin
                        b.ok   = 1'b1;
                        b.slot = fired_ids[k];
                        b.last = (k == fired_ids.size() - 1);
                        table_replies.push_back(b);
                    end
                end
            end
            ACT_TAKE: begin
                b.ok = ev_pending;
                ev_pending = 1'b0;
                table_replies.push_back(b);
            end
            default: begin
                // unused codes leave the table alone
                table_replies.push_back(b);
            end
        endcase
    endtask

    function automatic alarm_step_t mk_step(logic [ACT_W-1:0] act, logic [TIME_W-1:0] now,
            logic [TIME_W-1:0] dly, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
            logic typed, logic ok, logic [SLOT_W-1:0] slot, logic [REG_W-1:0] left);
        alarm_step_t st;
        st.req   = '{action: act, now: now, delay: dly, id: id, owner: tag};
        st.typed = typed;
        st.want  = '{ok: ok, slot: slot, left: left, nearest: '0, last: 1'b1};
        return st;
    endfunction

    // random request: time mostly creeps forward, ids mostly aim at real slots
    function automatic alarm_req_t next_random_req();
        alarm_req_t r;
        int         p, s;
        if ($urandom_range(99) < 5)
            wall = wall + $urandom_range(500, 3000);
        else
            wall = wall + $urandom_range(0, 30);
        r.now = ($urandom_range(99) < 4) ? $urandom() : wall;
        p = $urandom_range(99);
        if (p < 30)      r.action = ACT_SET;
        else if (p < 45) r.action = ACT_CANCEL;
        else if (p < 65) r.action = ACT_QUERY;
        else if (p < 90) r.action = ACT_SCAN;
        else if (p < 97) r.action = ACT_TAKE;
        else             r.action = ACT_W'($urandom_range(5, 7));
        p = $urandom_range(99);
        if (p < 70)      r.delay = $urandom_range(1, 150);
        else if (p < 78) r.delay = '0;
        else if (p < 86) r.delay = $urandom() | 32'h8000_0000;
        else             r.delay = $urandom();
        r.owner = ($urandom_range(99) < 90) ? tag_pool[$urandom_range(0, 3)]
                                            : TAG_W'($urandom_range(0, 255));
        if ($urandom_range(99) < 75) begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            r.id = ID_W'(s + 1);
            if (r.action != ACT_SET && sl_used[s] && $urandom_range(99) < 85)
                r.owner = sl_owner[s];
        end else begin
            r.id = ID_W'($urandom_range(0, 255));
        end
        return r;
    endfunction

    // present one beat, hold it until taken, then book its replies
    task automatic offer_request(input alarm_req_t r, input logic typed,
            input alarm_beat_t want);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= r.action;
        i_now_seconds   <= r.now;
        i_delay_seconds <= r.delay;
        i_alarm_id      <= r.id;
        i_owner_tag     <= r.owner;
        do @(posedge i_clk); while (o_in_stall);
        step_alarm_table(r);
        if (typed) begin
            void'(table_replies.pop_back());
            table_replies.push_back(want);
        end
    endtask

    task automatic hush_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // only with the block drained: nothing owed and a short settle
    task automatic set_regs(input logic [REG_W-1:0] md, input logic [REG_W-1:0] ra);
        while (table_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_DELAY;
        i_cfg_data  <= md;
        md_reg = md;
        @(negedge i_clk);
        i_cfg_index <= CFG_RECLAIM_AGE;
        i_cfg_data  <= ra;
        ra_reg = ra;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [REG_W-1:0] md, input logic [REG_W-1:0] ra,
            input logic [TIME_W-1:0] start, input int n, input logic quiet,
            input logic squeeze);
        set_regs(md, ra);
        wall = start;
        calm = quiet;
        if (squeeze)
            squeeze_asked++;
        repeat (n) offer_request(next_random_req(), 1'b0, '0);
        hush_input();
        calm = 1'b0;
    endtask

    // receiver: random back-pressure, a long hold-off on request, none when calm
    always @(negedge i_clk) begin
        if (squeeze_seen != squeeze_asked) begin
            squeeze_seen = squeeze_asked;
            hold_cnt = 250;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 27);
        end
    end

    // compare each accepted result beat with the oldest one owed
    always @(posedge i_clk) begin : reply_check
        alarm_beat_t got, want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = '{ok: o_ok, slot: o_slot_id, left: o_seconds_left,
                    nearest: o_nearest_deadline, last: o_last};
            if (table_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: ok=%0b slot=%0d left=%0d nearest=%0d last=%0b",
                             got.ok, got.slot, got.left, got.nearest, got.last);
            end else begin
                want = table_replies.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("beat mismatch: exp ok=%0b slot=%0d left=%0d near=%0d last=%0b",
                                 want.ok, want.slot, want.left, want.nearest, want.last,
                                 " got ok=%0b slot=%0d left=%0d near=%0d last=%0b",
                                 got.ok, got.slot, got.left, got.nearest, got.last);
                end
            end
        end
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sl_used[i]     = 1'b0;
            sl_fired[i]    = 1'b0;
            sl_deadline[i] = '0;
            sl_owner[i]    = '0;
        end
        ev_pending = 1'b0;
        md_reg     = MAX_DELAY_RST;
        ra_reg     = RECLAIM_AGE_RST;

        // directed rows, register reset values in force
        plan.push_back(mk_step(ACT_TAKE,   0, 0, 0, 0, 1, 0, 0, 0));      // nothing pending
        plan.push_back(mk_step(ACT_SCAN,   0, 0, 0, 0, 1, 0, 0, 0));      // empty table
        plan.push_back(mk_step(ACT_QUERY,  0, 0, 0, 0, 1, 0, 0, 0));      // id zero
        plan.push_back(mk_step(ACT_CANCEL, 0, 0, 8'hFF, 8'hFF, 1, 0, 0, 0)); // id past table
        plan.push_back(mk_step(ACT_W'(5), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                               1, 0, 0, 0));                              // unused code
        plan.push_back(mk_step(ACT_SET, 100, 32'h8000_0000, 0, 8'hAA, 1, 1, 1, 0)); // negative
        plan.push_back(mk_step(ACT_SET, 100, 0, 0, 8'h55, 1, 1, 2, 0));   // zero delay
        plan.push_back(mk_step(ACT_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 8'hFF,
                               1, 1, 3, 0));                              // deadline saturates
        plan.push_back(mk_step(ACT_SET, 1000, 5000, 0, 8'h00, 1, 1, 4, 0));
        plan.push_back(mk_step(ACT_QUERY, 50, 0, 1, 8'h55, 1, 0, 0, 0));  // foreign owner
        plan.push_back(mk_step(ACT_QUERY, 1000, 0, 4, 8'h00, 1, 1, 0, 5000));
        plan.push_back(mk_step(ACT_QUERY, 0, 0, 3, 8'hFF, 1, 1, 0, 24'hFF_FFFF)); // left clips
        plan.push_back(mk_step(ACT_SCAN, 101, 0, 0, 0, 0, 0, 0, 0));      // two slots fire
        plan.push_back(mk_step(ACT_TAKE, 101, 0, 0, 0, 1, 1, 0, 0));
        plan.push_back(mk_step(ACT_TAKE, 101, 0, 0, 0, 1, 0, 0, 0));      // flag now clear
        plan.push_back(mk_step(ACT_QUERY, 200, 0, 1, 8'hAA, 0, 0, 0, 0)); // fired slot
        plan.push_back(mk_step(ACT_CANCEL, 200, 0, 2, 8'h55, 1, 1, 0, 0));
        plan.push_back(mk_step(ACT_SET, 200, 32'h7FFF_FFFF, 0, 8'h11, 0, 0, 0, 0)); // clamp
        plan.push_back(mk_step(ACT_SET, 200, 1, 0, 8'h22, 0, 0, 0, 0));
        plan.push_back(mk_step(ACT_SET, 200, 300, 0, 8'h33, 0, 0, 0, 0));
        plan.push_back(mk_step(ACT_SET, 200, 301, 0, 8'h44, 0, 0, 0, 0));
        plan.push_back(mk_step(ACT_SET, 200, 302, 0, 8'h55, 0, 0, 0, 0));
        plan.push_back(mk_step(ACT_SET, 300, 10, 0, 8'h66, 1, 0, 0, 0));  // table full
        plan.push_back(mk_step(ACT_SET, 702, 50, 0, 8'h77, 0, 0, 0, 0));  // reclaim fired slot
        plan.push_back(mk_step(ACT_SCAN, 6000, 0, 0, 0, 0, 0, 0, 0));     // many fire at once

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            offer_request(plan[k].req, plan[k].typed, plan[k].want);
        hush_input();

        // random phases across register settings, extremes included
        run_phase(24'hFF_FFFF, 24'd0,        32'd2000,       50, 1'b0, 1'b0);
        run_phase(24'd1,       24'hFF_FFFF,  32'd100,        50, 1'b1, 1'b0);
        run_phase(24'd0,       24'd5,        32'd0,          50, 1'b0, 1'b1);
        run_phase(24'd200,     24'd60,       32'hFFFF_F800,  50, 1'b0, 1'b0);
        run_phase(MAX_DELAY_RST, RECLAIM_AGE_RST, 32'd50000, 50, 1'b0, 1'b0);
        run_phase(24'd40,      24'd0,        32'd9000,       50, 1'b0, 1'b0);

        // drain, then allow a full slot walk plus emit time
        while (table_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_cnt == 0 && table_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
src/oast_pkg.sv
src/owned_alarm_slot_table_unit.sv
tb/sv/tb_owned_alarm_slot_table_unit.sv
